// File: rtl/core/smed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smed_pkg: shared types and constants for the sort and median block
// Value width, default capacity and the structs that pass between the
// insertion cells and the chain controller.
// ----------------------------------------------------------------------------
package smed_pkg;

  localparam int VALUE_W        = 32;
  localparam int MAX_VALUES_DEF = 64;

  // What one cell shows to its neighbours
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      gt;     // holds a value greater than the arriving one
  } cell_t;

  // Commands broadcast along the chain
  typedef struct packed {
    logic ins;   // place the arriving value, shift larger ones up
    logic pop;   // shift every cell down towards the head
    logic clr;   // empty the whole chain
  } chain_ctrl_t;

endpackage

// File: rtl/core/smed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smed_cell: one insertion cell of the sorting chain
// Holds one value. On insert it keeps its value, takes the arriving value or
// takes the lower neighbour's value; on pop it takes the upper neighbour's.
// ----------------------------------------------------------------------------
module smed_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  smed_pkg::chain_ctrl_t                  ctrl,
  input  logic signed [smed_pkg::VALUE_W-1:0]    in_value,
  input  smed_pkg::cell_t                        lower,
  input  smed_pkg::cell_t                        upper,
  output smed_pkg::cell_t                        self_out
);
  import smed_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic                      valid;
  logic                      gt;

  // Compare against the broadcast value
  assign gt = valid && (value > in_value);

  assign self_out.value = value;
  assign self_out.valid = valid;
  assign self_out.gt    = gt;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (lower.gt || gt || (!valid && lower.valid)) begin
        valid <= 1'b1;
      end
    end else if (ctrl.pop) begin
      valid <= upper.valid;
    end
  end

  // Move the payload
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (lower.gt) begin
        value <= lower.value;
      end else if (gt || (!valid && lower.valid)) begin
        value <= in_value;
      end
    end else if (ctrl.pop) begin
      value <= upper.value;
    end
  end

endmodule

// File: rtl/core/smed_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smed_chain: row of insertion cells kept in ascending order
// Cell 0 holds the smallest value; a pop hands every value one cell down.
// ----------------------------------------------------------------------------
module smed_chain #(
  parameter int MAX_VALUES = smed_pkg::MAX_VALUES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smed_pkg::chain_ctrl_t                ctrl,
  input  logic signed [smed_pkg::VALUE_W-1:0]  in_value,
  output logic signed [smed_pkg::VALUE_W-1:0]  head_value,
  output logic                                 full
);
  import smed_pkg::*;

  cell_t cells [MAX_VALUES];
  cell_t below [MAX_VALUES];
  cell_t above [MAX_VALUES];

  // Build the row, tie off both ends
  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign below[i] = '{value: '0, valid: 1'b1, gt: 1'b0};
    end else begin : g_mid
      assign below[i] = cells[i-1];
    end
    if (i == MAX_VALUES - 1) begin : g_last
      assign above[i] = '{value: '0, valid: 1'b0, gt: 1'b0};
    end else begin : g_inner
      assign above[i] = cells[i+1];
    end

    smed_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .in_value (in_value),
      .lower    (below[i]),
      .upper    (above[i]),
      .self_out (cells[i])
    );
  end

  assign head_value = cells[0].value;
  assign full       = cells[MAX_VALUES-1].valid;

endmodule

// File: rtl/core/sort_and_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_median: ordered store with sorted-list or median output
// Loads a set of signed values into an insertion chain and emits either the
// whole sorted list or the median of the set.
// ----------------------------------------------------------------------------
// Values arrive one per beat, the last of a set marked by tlast; each beat is
// placed in order by the insertion chain as it is accepted, so loading runs
// at one beat per clock. Values beyond MAX_VALUES are dropped and every result
// of that set carries tuser = 1. After the marked beat the chain is drained
// from its smallest end at one value per cycle while the output side accepts:
// mode 0 gives N result beats and mode 1 gives one median beat. Input is
// held off while a set drains. output_mode is sampled with the marked beat
// and may be written only while the block idles.
// ----------------------------------------------------------------------------
module sort_and_median #(
  parameter int MAX_VALUES = smed_pkg::MAX_VALUES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration: output_mode
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,       // output_mode
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [smed_pkg::VALUE_W-1:0]        s_axis_tdata,   // [31:0] sample_value
  input  logic                                s_axis_tlast,   // end_of_set
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [smed_pkg::VALUE_W-1:0]        m_axis_tdata,   // [31:0] result_value
  output logic                                m_axis_tlast,   // final_result
  output logic                                m_axis_tuser    // capacity_exceeded
);
  import smed_pkg::*;

  localparam int CNT_W = $clog2(MAX_VALUES + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam logic MODE_LIST   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  logic                       state;
  logic                       output_mode;
  logic                       mode_lat;
  logic                       dropped;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           idx;
  logic signed [VALUE_W-1:0]  lo_value;

  chain_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0]  head_value;
  logic                       full;

  logic                       in_beat;
  logic                       out_beat;
  logic                       step;
  logic [CNT_W-1:0]           half;
  logic                       odd;
  logic                       emit;
  logic                       emit_last;
  logic signed [VALUE_W-1:0]  emit_value;
  logic signed [VALUE_W:0]    pair_sum;
  logic signed [VALUE_W:0]    pair_adj;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_LOAD);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign step          = (state == ST_DRAIN) && (!m_axis_tvalid || m_axis_tready);

  assign half = cnt >> 1;
  assign odd  = cnt[0];

  // Mean of the two middle values, truncated towards zero
  assign pair_sum = {lo_value[VALUE_W-1], lo_value} + {head_value[VALUE_W-1], head_value};
  assign pair_adj = pair_sum + {{VALUE_W{1'b0}}, pair_sum[VALUE_W] & pair_sum[0]};

  // Decide what the current drain step emits
  always_comb begin
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_value = head_value;
    case (mode_lat)
      MODE_LIST: begin
        emit      = 1'b1;
        emit_last = (idx == cnt - CNT_W'(1));
      end
      MODE_MEDIAN: begin
        if (idx == half) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (!odd) begin
            emit_value = pair_adj[VALUE_W:1];
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Chain commands
  always_comb begin
    ctrl.ins = in_beat && !full;
    ctrl.pop = step;
    ctrl.clr = step && emit && emit_last;
  end

  smed_chain #(
    .MAX_VALUES (MAX_VALUES)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_value   (s_axis_tdata),
    .head_value (head_value),
    .full       (full)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_MEDIAN;
    end else if (cfg_valid && cfg_ready) begin
      output_mode <= cfg_data;
    end
  end

  // Load and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      cnt     <= '0;
      idx     <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_beat) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state <= ST_DRAIN;
              idx   <= '0;
            end
          end
        end
        ST_DRAIN: begin
          if (step) begin
            idx <= idx + CNT_W'(1);
            if (emit && emit_last) begin
              state   <= ST_LOAD;
              cnt     <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Latch the mode with the marked beat
  always_ff @(posedge clk) begin
    if (in_beat && s_axis_tlast) begin
      mode_lat <= output_mode;
    end
  end

  // Hold the lower middle value for an even count
  always_ff @(posedge clk) begin
    if (step && (idx == half - CNT_W'(1))) begin
      lo_value <= head_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_beat) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      m_axis_tdata <= emit_value;
      m_axis_tlast <= emit_last;
      m_axis_tuser <= dropped;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sort_and_median
// Feeds sets of signed values in both output modes and compares every result
// beat with an in-bench ordered store that sorts each set and forms its list
// or median. A directed table with extremes, even/odd medians and equal
// values comes first. Random sets follow, including full and overflowing
// sets, with random gaps on both streams and long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

  import smed_pkg::*;

  localparam int CAPACITY        = MAX_VALUES_DEF;
  localparam int SETTLE_CYCLES   = CAPACITY + 8;   // drain time after the last beat
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_ITEMS    = 175;

  localparam logic MODE_LIST   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      fin;
    logic                      over;
  } sorted_beat_t;

  typedef enum logic {ROW_BEAT, ROW_MODE} plan_kind_t;

  typedef struct packed {
    plan_kind_t                kind;
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
    logic                      mark;
    logic                      typed;
    logic signed [VALUE_W-1:0] want;
  } plan_row_t;

  // Directed sets: typed medians where they are obvious, predicted otherwise
  plan_row_t plan_rows [25] = '{
    '{ROW_BEAT, 1'b0, VAL_MIN,   1'b1, 1'b1, VAL_MIN},
    '{ROW_BEAT, 1'b0, VAL_MAX,   1'b1, 1'b1, VAL_MAX},
    '{ROW_BEAT, 1'b0, VAL_MAX,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, VAL_MAX,   1'b1, 1'b1, VAL_MAX},
    '{ROW_BEAT, 1'b0, VAL_MIN,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, VAL_MIN,   1'b1, 1'b1, VAL_MIN},
    '{ROW_BEAT, 1'b0, -32'sd3,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd0,    1'b1, 1'b1, -32'sd1},
    '{ROW_BEAT, 1'b0, VAL_MIN,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, VAL_MAX,   1'b1, 1'b1, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd5,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, -32'sd7,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd3,    1'b1, 1'b1, 32'sd3},
    '{ROW_MODE, MODE_LIST,   32'sd0, 1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd3,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd1,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd2,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd1,    1'b1, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, VAL_MAX,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, -32'sd1,   1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd0,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, VAL_MIN,   1'b1, 1'b0, 32'sd0},
    '{ROW_MODE, MODE_MEDIAN, 32'sd0, 1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd1,    1'b0, 1'b0, 32'sd0},
    '{ROW_BEAT, 1'b0, 32'sd4,    1'b1, 1'b1, 32'sd2}
  };

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic                cfg_data      = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [VALUE_W-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]  m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  // Ordered store mirrored in the bench
  logic signed [VALUE_W-1:0] ordered_store [$];
  logic                      dropped_any = 1'b0;
  logic                      mode_now    = MODE_MEDIAN;
  sorted_beat_t              set_results [$];
  sorted_beat_t              awaited_results [$];

  int   fault_count   = 0;
  int   idle_cycles   = 0;
  logic steady_feed   = 1'b0;
  logic hold_off_req  = 1'b0;

  sort_and_median u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Place one accepted value and, on the marked beat, form the set's results
  task automatic place_value(input logic signed [VALUE_W-1:0] v, input logic mark);
    int                        pos;
    int                        half;
    logic signed [VALUE_W:0]   pair_sum;
    sorted_beat_t              beat;
    set_results.delete();
    if (ordered_store.size() < CAPACITY) begin
      pos = ordered_store.size();
      while (pos > 0 && ordered_store[pos-1] > v) pos--;
      ordered_store.insert(pos, v);
    end else begin
      dropped_any = 1'b1;
    end
    if (mark) begin
      beat.over = dropped_any;
      if (mode_now == MODE_LIST) begin
        for (int i = 0; i < ordered_store.size(); i++) begin
          beat.value = ordered_store[i];
          beat.fin   = (i == ordered_store.size() - 1);
          set_results.push_back(beat);
        end
      end else begin
        half = ordered_store.size() / 2;
        if (ordered_store.size() % 2 == 1) begin
          beat.value = ordered_store[half];
        end else begin
          // sum at 33 bits, halve towards zero
          pair_sum   = (VALUE_W+1)'(ordered_store[half-1]) +
                       (VALUE_W+1)'(ordered_store[half]);
          beat.value = VALUE_W'(pair_sum / 33'sd2);
        end
        beat.fin = 1'b1;
        set_results.push_back(beat);
      end
      ordered_store.delete();
      dropped_any = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(
      input logic signed [VALUE_W-1:0] prev);
    int r;
    r = $urandom_range(0, 19);
    if (r < 9)  return $urandom;
    if (r < 13) return $signed($urandom_range(0, 20)) - 10;
    if (r < 16) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return prev;   // repeat to exercise equal values
  endfunction

  // Offer one beat after a random gap (none on a steady feed), wait for its acceptance, predict
  task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic mark,
                           input logic typed, input logic signed [VALUE_W-1:0] want);
    int           gap;
    sorted_beat_t beat;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= mark;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    place_value(v, mark);
    if (typed) begin
      beat.value = want;
      beat.fin   = 1'b1;
      beat.over  = 1'b0;
      awaited_results.push_back(beat);
    end else begin
      foreach (set_results[i]) awaited_results.push_back(set_results[i]);
    end
  endtask

  // Let the block drain completely before touching the mode
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  // Stimulus: directed table, then random sets
  initial begin : stimulus
    int                        len;
    int                        set_no;
    int                        rand_items;
    logic signed [VALUE_W-1:0] v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_MODE) begin
        write_mode(plan_rows[i].mode);
      end else begin
        send_beat(plan_rows[i].value, plan_rows[i].mark, plan_rows[i].typed,
                  plan_rows[i].want);
      end
    end

    rand_items = 0;
    set_no     = 0;
    v          = 32'sd0;
    while (rand_items < RANDOM_ITEMS) begin
      if (set_no == 0 || set_no == 12) hold_off_req = 1'b1;
      case (set_no)
        2: begin
          write_mode(MODE_MEDIAN);
          len = CAPACITY;
        end
        4: begin
          write_mode(MODE_LIST);
          len = CAPACITY + 2;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        end
      endcase
      steady_feed = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        v = pick_value(v);
        send_beat(v, k == len - 1, 1'b0, 32'sd0);
        rand_items++;
      end
      set_no++;
    end

    wait_idle();
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("sort_and_median: match");
    end else begin
      $display("sort_and_median: mismatch");
    end
    $finish;
  end

  // Output side: random stalls, calm stretches, and long hold-offs on request
  initial begin : result_sink
    int stall_left;
    int cycle_no;
    stall_left = 0;
    cycle_no   = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (hold_off_req && !rst) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ((cycle_no / 128) % 4 == 3) begin
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          7, 8: begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
          end
          9: begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(8, 30);
          end
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each result beat with the oldest awaited one
  always @(posedge clk) begin : check_results
    sorted_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result with nothing awaited: value %0d last %0b flag %0b",
                   $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.fin ||
            m_axis_tuser !== want.over) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result differs: expected value %0d last %0b flag %0b, got %0d %0b %0b",
                     want.value, want.fin, want.over,
                     $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sort_and_median: mismatch");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/core/smed_pkg.sv
rtl/core/smed_cell.sv
rtl/core/smed_chain.sv
rtl/core/sort_and_median.sv
tb/sv/testbench.sv
